### sv/spae_pkg.sv
// ----------------------------------------------------------------------------
// Sparse polynomial evaluator package
// Operation codes, fixed field widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
package spae_pkg;

   localparam int OP_W        = 2;
   localparam int COEFF_W     = 32;
   localparam int POINT_W     = 32;
   localparam int TEXP_W      = 8;
   localparam int VALUE_W     = 64;
   localparam int HALF_W      = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int DEG_W       = 8;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_EVAL  = 2'd2;

   typedef struct packed {
      logic load;
      logic clear_table;
      logic idx_inc;
      logic rd;
      logic wr;
      logic wr_merge;
      logic set_full;
      logic term_load;
      logic mul_start;
      logic mul_sq;
      logic acc_take;
      logic base_take;
      logic sum_add;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            at_end;
      logic            exp_match;
      logic            table_full;
      logic            ebits_zero;
      logic            ebits_lsb;
      logic            mul_done;
   } sts_type;

endpackage

### sv/sparse_polynomial_accumulate_eval.sv
// ----------------------------------------------------------------------------
// Sparse polynomial accumulator and evaluator
// Clear empties the table and an unused code only responds; an add term scans
// the entries for its exponent, merges into a match, else inserts or drops it.
// Evaluate uses one multiply for each set exponent bit and each squaring, all
// on the shared iterative multiplier.
// One beat in flight at a time; the next beat is taken while a result waits.
// Reset empties the table and clears the handshake; term storage is not reset.
// ----------------------------------------------------------------------------
module sparse_polynomial_accumulate_eval
   import spae_pkg::*;
#(
   parameter int MAX_TERMS = 16,
   parameter int EXP_BITS  = 8
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [COEFF_W-1:0] req_term_coeff,
   input  logic [TEXP_W-1:0]         req_term_exponent,
   input  logic signed [POINT_W-1:0] req_eval_point,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic [COUNT_OUT_W-1:0]    rsp_term_count,
   output logic [DEG_W-1:0]          rsp_poly_degree,
   output logic                      rsp_store_full
);

   cmd_type cmd;
   sts_type sts;

   spae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   spae_datapath #(
      .MAX_TERMS (MAX_TERMS),
      .EXP_BITS  (EXP_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_term_coeff    (req_term_coeff),
      .req_term_exponent (req_term_exponent),
      .req_eval_point    (req_eval_point),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_value         (rsp_value),
      .rsp_term_count    (rsp_term_count),
      .rsp_poly_degree   (rsp_poly_degree),
      .rsp_store_full    (rsp_store_full)
   );

   property p_accept_goes_busy;
      @(posedge clock) disable iff (reset)
         (req_valid && !req_stall) |=> req_stall;
   endproperty
   a_accept_goes_busy: assert property (p_accept_goes_busy)
      else $error("accepted beat did not make the block busy");

   property p_full_at_capacity;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_store_full) |-> (rsp_term_count == COUNT_OUT_W'(MAX_TERMS));
   endproperty
   a_full_at_capacity: assert property (p_full_at_capacity)
      else $error("dropped term reported with table not at capacity");

   property p_full_has_no_value;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_store_full) |-> (rsp_value == '0);
   endproperty
   a_full_has_no_value: assert property (p_full_has_no_value)
      else $error("dropped term reported with nonzero value");

endmodule

### sv/spae_mul.sv
// ----------------------------------------------------------------------------
// Iterative 64-bit wrapping multiplier
// Low 64 bits of a 64 x 64 product from three 32 x 32 partial products.
// ----------------------------------------------------------------------------
module spae_mul
   import spae_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] op_a,
   input  logic [VALUE_W-1:0] op_b,
   output logic               done,
   output logic [VALUE_W-1:0] prod
);

   logic [VALUE_W-1:0] a_ff;
   logic [VALUE_W-1:0] b_ff;
   logic [VALUE_W-1:0] pp_ff;
   logic [VALUE_W-1:0] acc_ff;
   logic [1:0]         ph_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [HALF_W-1:0]  sel_a;
   logic [HALF_W-1:0]  sel_b;

   always_comb begin
      case (ph_ff)
         2'd1: begin
            sel_a = a_ff[HALF_W-1:0];
            sel_b = b_ff[VALUE_W-1:HALF_W];
         end
         2'd2: begin
            sel_a = a_ff[VALUE_W-1:HALF_W];
            sel_b = b_ff[HALF_W-1:0];
         end
         default: begin
            sel_a = a_ff[HALF_W-1:0];
            sel_b = b_ff[HALF_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      if (busy_ff) begin
         pp_ff <= {{HALF_W{1'b0}}, sel_a} * {{HALF_W{1'b0}}, sel_b};
         case (ph_ff)
            2'd1: acc_ff <= pp_ff;
            2'd2, 2'd3: acc_ff[VALUE_W-1:HALF_W] <= acc_ff[VALUE_W-1:HALF_W] +
                                                   pp_ff[HALF_W-1:0];
            default: acc_ff <= acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ph_ff   <= 2'd0;
      end else begin
         done_ff <= busy_ff && (ph_ff == 2'd3);
         if (start) begin
            busy_ff <= 1'b1;
            ph_ff   <= 2'd0;
         end else if (busy_ff) begin
            ph_ff <= ph_ff + 2'd1;
            if (ph_ff == 2'd3) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

### sv/spae_datapath.sv
// ----------------------------------------------------------------------------
// Sparse polynomial datapath
// Term tables, scan index, power and sum registers, and the result register.
// ----------------------------------------------------------------------------
module spae_datapath
   import spae_pkg::*;
#(
   parameter int MAX_TERMS = 16,
   parameter int EXP_BITS  = 8
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [COEFF_W-1:0] req_term_coeff,
   input  logic [TEXP_W-1:0]         req_term_exponent,
   input  logic signed [POINT_W-1:0] req_eval_point,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic [COUNT_OUT_W-1:0]    rsp_term_count,
   output logic [DEG_W-1:0]          rsp_poly_degree,
   output logic                      rsp_store_full
);

   localparam int CNT_W  = $clog2(MAX_TERMS + 1);
   localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   logic [COEFF_W-1:0]      coeff_mem [MAX_TERMS];
   logic [EXP_BITS-1:0]     exp_mem   [MAX_TERMS];

   logic [OP_W-1:0]         op_ff;
   logic [COEFF_W-1:0]      tcoeff_ff;
   logic [EXP_BITS-1:0]     texp_ff;
   logic [POINT_W-1:0]      point_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [EXP_BITS-1:0]     max_ff;
   logic [CNT_W-1:0]        idx_ff;
   logic [COEFF_W-1:0]      rd_coeff_ff;
   logic [EXP_BITS-1:0]     rd_exp_ff;
   logic [VALUE_W-1:0]      tacc_ff;
   logic [VALUE_W-1:0]      base_ff;
   logic [EXP_BITS-1:0]     ebits_ff;
   logic [VALUE_W-1:0]      sum_ff;
   logic                    full_ff;
   logic [VALUE_W-1:0]      rsp_value_ff;
   logic [COUNT_OUT_W-1:0]  rsp_count_ff;
   logic [DEG_W-1:0]        rsp_deg_ff;
   logic                    rsp_full_ff;

   logic [ADDR_W-1:0]               addr;
   logic [COEFF_W-1:0]              wr_coeff;
   logic [EXP_BITS+TEXP_W-1:0]      texp_ext;
   logic [CNT_W+COUNT_OUT_W-1:0]    count_ext;
   logic [EXP_BITS+DEG_W-1:0]       deg_ext;
   logic [VALUE_W-1:0]              mul_a;
   logic                            mul_done;
   logic [VALUE_W-1:0]              mul_prod;

   assign addr      = idx_ff[ADDR_W-1:0];
   assign wr_coeff  = cmd.wr_merge ? (rd_coeff_ff + tcoeff_ff) : tcoeff_ff;
   assign texp_ext  = {{EXP_BITS{1'b0}}, req_term_exponent};
   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_ff};
   assign deg_ext   = {{DEG_W{1'b0}}, max_ff};
   assign mul_a     = cmd.mul_sq ? base_ff : tacc_ff;

   spae_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .op_a  (mul_a),
      .op_b  (base_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         coeff_mem[addr] <= wr_coeff;
         exp_mem[addr]   <= texp_ff;
      end
      if (cmd.rd) begin
         rd_coeff_ff <= coeff_mem[addr];
         rd_exp_ff   <= exp_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         tcoeff_ff <= req_term_coeff;
         texp_ff   <= texp_ext[EXP_BITS-1:0];
         point_ff  <= req_eval_point;
         idx_ff    <= '0;
         sum_ff    <= '0;
         full_ff   <= 1'b0;
      end else begin
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (cmd.set_full) begin
            full_ff <= 1'b1;
         end
         if (cmd.sum_add) begin
            sum_ff <= sum_ff + tacc_ff;
         end
      end
      if (cmd.term_load) begin
         tacc_ff  <= {{(VALUE_W-COEFF_W){rd_coeff_ff[COEFF_W-1]}}, rd_coeff_ff};
         base_ff  <= {{(VALUE_W-POINT_W){point_ff[POINT_W-1]}}, point_ff};
         ebits_ff <= rd_exp_ff;
      end else if (cmd.acc_take) begin
         tacc_ff     <= mul_prod;
         ebits_ff[0] <= 1'b0;
      end else if (cmd.base_take) begin
         base_ff  <= mul_prod;
         ebits_ff <= ebits_ff >> 1;
      end
      if (cmd.rsp_load) begin
         rsp_value_ff <= sum_ff;
         rsp_count_ff <= count_ext[COUNT_OUT_W-1:0];
         rsp_deg_ff   <= deg_ext[DEG_W-1:0];
         rsp_full_ff  <= full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= '0;
      end else if (cmd.clear_table) begin
         count_ff <= '0;
         max_ff   <= '0;
      end else if (cmd.wr && !cmd.wr_merge) begin
         count_ff <= count_ff + CNT_W'(1);
         if ((count_ff == '0) || (texp_ff > max_ff)) begin
            max_ff <= texp_ff;
         end
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.at_end     = (idx_ff == count_ff);
      sts.exp_match  = (rd_exp_ff == texp_ff);
      sts.table_full = (count_ff == CNT_W'(MAX_TERMS));
      sts.ebits_zero = (ebits_ff == '0);
      sts.ebits_lsb  = ebits_ff[0];
      sts.mul_done   = mul_done;
   end

   assign rsp_value       = rsp_value_ff;
   assign rsp_term_count  = rsp_count_ff;
   assign rsp_poly_degree = rsp_deg_ff;
   assign rsp_store_full  = rsp_full_ff;

endmodule

### sv/spae_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse polynomial controller
// Sequences clear, merge/insert scans and term-by-term evaluation.
// ----------------------------------------------------------------------------
module spae_ctrl
   import spae_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_AREAD    = 4'd2;
   localparam logic [3:0] S_ACMP     = 4'd3;
   localparam logic [3:0] S_AINS     = 4'd4;
   localparam logic [3:0] S_EREAD    = 4'd5;
   localparam logic [3:0] S_ELOAD    = 4'd6;
   localparam logic [3:0] S_ESTEP    = 4'd7;
   localparam logic [3:0] S_EWAITA   = 4'd8;
   localparam logic [3:0] S_EWAITS   = 4'd9;
   localparam logic [3:0] S_EADD     = 4'd10;
   localparam logic [3:0] S_DONE     = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.op)
               OP_CLEAR: begin
                  cmd.clear_table = 1'b1;
                  state_in        = S_DONE;
               end
               OP_ADD:  state_in = S_AREAD;
               OP_EVAL: state_in = S_EREAD;
               default: state_in = S_DONE;
            endcase
         end
         S_AREAD: begin
            if (sts.at_end) begin
               state_in = S_AINS;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_ACMP;
            end
         end
         S_ACMP: begin
            if (sts.exp_match) begin
               cmd.wr       = 1'b1;
               cmd.wr_merge = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_AREAD;
            end
         end
         S_AINS: begin
            if (sts.table_full) begin
               cmd.set_full = 1'b1;
            end else begin
               cmd.wr = 1'b1;
            end
            state_in = S_DONE;
         end
         S_EREAD: begin
            if (sts.at_end) begin
               state_in = S_DONE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_ELOAD;
            end
         end
         S_ELOAD: begin
            cmd.term_load = 1'b1;
            state_in      = S_ESTEP;
         end
         S_ESTEP: begin
            if (sts.ebits_zero) begin
               state_in = S_EADD;
            end else if (sts.ebits_lsb) begin
               cmd.mul_start = 1'b1;
               state_in      = S_EWAITA;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sq    = 1'b1;
               state_in      = S_EWAITS;
            end
         end
         S_EWAITA: begin
            if (sts.mul_done) begin
               cmd.acc_take = 1'b1;
               state_in     = S_ESTEP;
            end
         end
         S_EWAITS: begin
            if (sts.mul_done) begin
               cmd.base_take = 1'b1;
               state_in      = S_ESTEP;
            end
         end
         S_EADD: begin
            cmd.sum_add = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = S_EREAD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### sim/poly_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial result checker
// Watches the request and result channels of the evaluator, keeps its own
// term table, predicts each result and compares it field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module poly_result_checker
   import spae_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [COEFF_W-1:0] req_term_coeff,
   input  logic [TEXP_W-1:0]         req_term_exponent,
   input  logic signed [POINT_W-1:0] req_eval_point,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [VALUE_W-1:0] rsp_value,
   input  logic [COUNT_OUT_W-1:0]    rsp_term_count,
   input  logic [DEG_W-1:0]          rsp_poly_degree,
   input  logic                      rsp_store_full,
   output int                        fault_count,
   output int                        outstanding
);

   localparam int TABLE_DEPTH = 16;

   typedef struct packed {
      logic [VALUE_W-1:0]     value;
      logic [COUNT_OUT_W-1:0] count;
      logic [DEG_W-1:0]       degree;
      logic                   dropped;
   } poly_result_type;

   logic [COEFF_W-1:0] coeff_tbl [TABLE_DEPTH];
   logic [TEXP_W-1:0]  exp_tbl [TABLE_DEPTH];
   int                 terms_held;
   logic [TEXP_W-1:0]  top_exp;
   poly_result_type    results_due [$];

   function automatic logic [VALUE_W-1:0] wrapped_power(logic [VALUE_W-1:0] base,
                                                        logic [TEXP_W-1:0] e);
      logic [VALUE_W-1:0] acc;
      acc = VALUE_W'(1);
      for (int b = 0; b < TEXP_W; b++) begin
         if (e[b]) acc = acc * base;
         base = base * base;
      end
      return acc;
   endfunction

   function automatic poly_result_type apply_term_op(logic [OP_W-1:0] op,
                                                     logic [COEFF_W-1:0] coeff,
                                                     logic [TEXP_W-1:0] expo,
                                                     logic [POINT_W-1:0] x);
      poly_result_type    r;
      int                 slot;
      logic [VALUE_W-1:0] xw;
      r = '0;
      slot = -1;
      xw = {{(VALUE_W-POINT_W){x[POINT_W-1]}}, x};
      case (op)
         OP_CLEAR: begin
            terms_held = 0;
            top_exp = '0;
         end
         OP_ADD: begin
            for (int i = 0; i < terms_held; i++)
               if (slot < 0 && exp_tbl[i] == expo) slot = i;
            if (slot >= 0) begin
               coeff_tbl[slot] = coeff_tbl[slot] + coeff;
            end else if (terms_held < TABLE_DEPTH) begin
               coeff_tbl[terms_held] = coeff;
               exp_tbl[terms_held] = expo;
               if (terms_held == 0 || expo > top_exp) top_exp = expo;
               terms_held++;
            end else begin
               r.dropped = 1'b1;
            end
         end
         OP_EVAL: begin
            for (int i = 0; i < terms_held; i++)
               r.value = r.value + {{(VALUE_W-COEFF_W){coeff_tbl[i][COEFF_W-1]}}, coeff_tbl[i]}
                                   * wrapped_power(xw, exp_tbl[i]);
         end
         default: ;
      endcase
      r.count = terms_held[COUNT_OUT_W-1:0];
      r.degree = (terms_held == 0) ? '0 : top_exp;
      return r;
   endfunction

   task automatic report_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      poly_result_type want;
      if (reset) begin
         terms_held = 0;
         top_exp = '0;
         results_due.delete();
         fault_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result beat: expected none, actual value %0h",
                        $time, rsp_value);
               fault_count++;
            end else begin
               want = results_due.pop_front();
               report_field("value", want.value, rsp_value);
               report_field("term_count", VALUE_W'(want.count), VALUE_W'(rsp_term_count));
               report_field("poly_degree", VALUE_W'(want.degree), VALUE_W'(rsp_poly_degree));
               report_field("store_full", VALUE_W'(want.dropped), VALUE_W'(rsp_store_full));
            end
         end
         if (req_valid && !req_stall)
            results_due.insert(results_due.size(),
                               apply_term_op(req_operation, req_term_coeff,
                                             req_term_exponent, req_eval_point));
      end
      outstanding = results_due.size();
   end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial evaluator testbench
// Drives directed term sequences (extreme coefficients and points, merges,
// coefficient wrap, full table, unused code) and then random clear/add/eval
// sequences with noise, under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;
   import spae_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET  = 1250;
   localparam int DRAIN_CYCLES = 4000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_operation = OP_CLEAR;
   logic signed [COEFF_W-1:0] req_term_coeff = '0;
   logic [TEXP_W-1:0]         req_term_exponent = '0;
   logic signed [POINT_W-1:0] req_eval_point = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_value;
   logic [COUNT_OUT_W-1:0]    rsp_term_count;
   logic [DEG_W-1:0]          rsp_poly_degree;
   logic                      rsp_store_full;
   int                        fault_count;
   int                        outstanding;
   int                        send_idle_pct = 30;
   int                        stall_pct = 50;
   int                        beats_sent = 0;

   sparse_polynomial_accumulate_eval dut (.*);

   poly_result_checker checker_i (.*);

   always #6 clock = ~clock;

   always @(negedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);

   task automatic send_term_op(logic [OP_W-1:0] op, logic [COEFF_W-1:0] coeff,
                               logic [TEXP_W-1:0] expo, logic [POINT_W-1:0] x);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_term_coeff <= coeff;
      req_term_exponent <= expo;
      req_eval_point <= x;
      do @(posedge clock); while (req_stall);
      if (op != OP_UNUSED) beats_sent++;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3, 4: return $urandom_range(6) - 3;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [TEXP_W-1:0] pick_exponent(int pool);
      case (pool)
         0: return TEXP_W'($urandom_range(7));
         1: return TEXP_W'($urandom_range(255));
         default: return ($urandom_range(1) != 0) ? TEXP_W'($urandom_range(255, 248))
                                                   : TEXP_W'($urandom_range(3));
      endcase
   endfunction

   initial begin
      logic [TEXP_W-1:0] fill_exp [16] = '{8'd200, 8'd255, 8'd3, 8'd0, 8'd17, 8'd128,
                                           8'd64, 8'd1, 8'd2, 8'd99, 8'd31, 8'd7,
                                           8'd150, 8'd90, 8'd45, 8'd12};
      int pool;
      int len;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_term_op(OP_EVAL, $urandom(), TEXP_W'($urandom()), 32'd5);
      for (int i = 0; i < 16; i++)
         send_term_op(OP_ADD, (i == 0) ? 32'h7fff_ffff : (i == 1) ? 32'h8000_0000 :
                              (i == 2) ? 32'h0 : $urandom(), fill_exp[i], $urandom());
      send_term_op(OP_ADD, 32'd1, 8'd200, $urandom());
      send_term_op(OP_ADD, $urandom(), 8'd250, $urandom());
      send_term_op(OP_EVAL, $urandom(), TEXP_W'($urandom()), 32'h8000_0000);
      send_term_op(OP_EVAL, $urandom(), TEXP_W'($urandom()), 32'h7fff_ffff);
      send_term_op(OP_EVAL, $urandom(), TEXP_W'($urandom()), 32'hffff_ffff);
      send_term_op(OP_UNUSED, $urandom(), TEXP_W'($urandom()), $urandom());
      send_term_op(OP_CLEAR, $urandom(), TEXP_W'($urandom()), $urandom());
      send_term_op(OP_EVAL, $urandom(), TEXP_W'($urandom()), $urandom());

      while (beats_sent < ITEM_TARGET) begin
         if (beats_sent < ITEM_TARGET / 3) begin
            send_idle_pct = 30;
            stall_pct = 50;
         end else if (beats_sent < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 50;
            stall_pct = 30;
         end else begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         if ($urandom_range(99) < 85) begin
            send_term_op(OP_CLEAR, $urandom(), TEXP_W'($urandom()), $urandom());
            pool = $urandom_range(2);
            len = $urandom_range(24, 1);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(99) < 25)
                  send_term_op(OP_EVAL, $urandom(), TEXP_W'($urandom()), pick_word());
               else
                  send_term_op(OP_ADD, pick_word(), pick_exponent(pool), $urandom());
            end
            repeat ($urandom_range(3, 1))
               send_term_op(OP_EVAL, $urandom(), TEXP_W'($urandom()), pick_word());
         end else begin
            repeat ($urandom_range(5, 1))
               send_term_op(OP_W'($urandom_range(3)), $urandom(), TEXP_W'($urandom()),
                            $urandom());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

### sparse_polynomial_accumulate_eval.f
sv/spae_pkg.sv
sv/spae_mul.sv
sv/spae_datapath.sv
sv/spae_ctrl.sv
sv/sparse_polynomial_accumulate_eval.sv
sim/poly_result_checker.sv
sim/testbench.sv
